// ===== rtl/tes_pkg.sv =====
// Triangle edge setup: shared types, widths and helper functions.
// No dependencies; imported by every RTL module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tes_pkg;

  localparam int VtxW    = 16;
  localparam int EdgeW   = 32;
  localparam int DivQW   = 32;
  localparam int DivBps  = 2;
  localparam int SlopeNW = 32;
  localparam int OffNW   = 44;

  typedef enum logic [1:0] {
    CASE_FLAT,
    CASE_FBOT,
    CASE_FTOP,
    CASE_SPLIT
  } tri_case_e;

  typedef struct packed {
    logic signed [VtxW-1:0] xlo;
    logic signed [VtxW-1:0] xmd;
    logic signed [VtxW-1:0] ylo;
    logic signed [VtxW-1:0] ymd;
    logic signed [VtxW-1:0] yhi;
    tri_case_e              kind;
    logic                   long_left;
    logic                   sg0;
    logic                   sg1;
    logic                   sg2;
    logic                   sg3;
  } side_t;

  typedef struct packed {
    logic signed [EdgeW-1:0] lx;
    logic signed [EdgeW-1:0] ls;
    logic signed [EdgeW-1:0] rx;
    logic signed [EdgeW-1:0] rs;
    logic signed [VtxW-1:0]  by;
    logic signed [VtxW-1:0]  ty;
    logic                    last;
    logic                    degen;
  } res_t;

  // integer part of Q12.4, truncated toward zero
  function automatic logic signed [12:0] int_part(logic signed [VtxW-1:0] q);
    logic signed [VtxW:0] e;
    logic signed [VtxW:0] m;
    logic signed [VtxW:0] r;
    e = {q[VtxW-1], q};
    m = -e;
    if (q[VtxW-1]) begin
      r = -(m >>> 4);
    end else begin
      r = e >>> 4;
    end
    return r[12:0];
  endfunction

  function automatic logic [VtxW-1:0] mag17(logic signed [VtxW:0] v);
    logic signed [VtxW:0] n;
    n = -v;
    return v[VtxW] ? n[VtxW-1:0] : v[VtxW-1:0];
  endfunction

  function automatic logic signed [EdgeW-1:0] sat_slope(logic neg, logic [DivQW-1:0] q);
    logic [DivQW-1:0] n;
    n = -q;
    if (!neg) begin
      return q[DivQW-1] ? {1'b0, {(EdgeW-1){1'b1}}} : q;
    end else begin
      return (q[DivQW-1] && (|q[DivQW-2:0])) ? {1'b1, {(EdgeW-1){1'b0}}} : n;
    end
  endfunction

  function automatic logic signed [EdgeW-1:0] to_q16(logic signed [VtxW-1:0] x);
    return {{4{x[VtxW-1]}}, x, 12'h000};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tes_div.sv =====
// Pipelined restoring unsigned divider, DivBps quotient bits per stage.
// Depends on tes_pkg for default widths.
`timescale 1ns / 1ps
`default_nettype none

module tes_div import tes_pkg::*; #(
  parameter int NW  = SlopeNW,
  parameter int QW  = DivQW,
  parameter int DW  = VtxW,
  parameter int BPS = DivBps
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               valid_o,
  output logic [QW-1:0]      quo_o
);

  localparam int NS = QW / BPS;

  logic [DW-1:0] rem_q [NS];
  logic [QW-1:0] acc_q [NS];
  logic [DW-1:0] den_q [NS];
  logic          vld_q [NS];

  logic [DW-1:0] rem_w [NS];
  logic [QW-1:0] acc_w [NS];
  logic [DW-1:0] den_w [NS];
  logic          vld_w [NS];
  logic [DW-1:0] rem_d [NS];
  logic [QW-1:0] acc_d [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    if (s == 0) begin : g_in
      assign rem_w[s] = DW'(num_i >> QW);
      assign acc_w[s] = num_i[QW-1:0];
      assign den_w[s] = den_i;
      assign vld_w[s] = valid_i;
    end else begin : g_chain
      assign rem_w[s] = rem_q[s-1];
      assign acc_w[s] = acc_q[s-1];
      assign den_w[s] = den_q[s-1];
      assign vld_w[s] = vld_q[s-1];
    end

    always_comb begin
      logic [DW:0]   t;
      logic [DW-1:0] r;
      logic [QW-1:0] a;
      r = rem_w[s];
      a = acc_w[s];
      for (int b = 0; b < BPS; b++) begin
        t = {r, a[QW-1]};
        a = {a[QW-2:0], 1'b0};
        if (t >= {1'b0, den_w[s]}) begin
          t    = t - {1'b0, den_w[s]};
          a[0] = 1'b1;
        end
        r = t[DW-1:0];
      end
      rem_d[s] = r;
      acc_d[s] = a;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_w[s];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= rem_d[s];
      acc_q[s] <= acc_d[s];
      den_q[s] <= den_w[s];
    end
  end

  assign valid_o = vld_q[NS-1];
  assign quo_o   = acc_q[NS-1];

endmodule

`default_nettype wire

// ===== rtl/triangle_edge_setup_core.sv =====
// Triangle edge setup top level: sort, edge differences, four pipelined
// dividers and trapezoid assembly. Depends on tes_pkg and tes_div.
//
// Usage: drive the three vertices (signed Q12.4) with start_i; the request
// is taken at a rising edge where start_i is high and busy_o is low.
// busy_o is high for one cycle after each accepted request, so requests
// cannot be taken back to back; the pipeline holds about 11 triangles.
// Results come out as one or two trapezoids, each shown for exactly one
// cycle with valid_o high; the second follows the first in the next cycle
// with last_o set. The dividers form a 16-stage pipeline (2 quotient bits
// per stage); around them lie the input capture, sort, difference,
// product, slope saturation and assembly stages.
// The receiver cannot stall: every result is taken in the cycle it shows.
// Reset clears all valid bits and busy_o; no request is lost across it
// other than those in flight, which are dropped.
`timescale 1ns / 1ps
`default_nettype none

module triangle_edge_setup_core import tes_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  output logic                         busy_o,
  input  wire logic signed [VtxW-1:0]  vertex_a_x_i,
  input  wire logic signed [VtxW-1:0]  vertex_a_y_i,
  input  wire logic signed [VtxW-1:0]  vertex_b_x_i,
  input  wire logic signed [VtxW-1:0]  vertex_b_y_i,
  input  wire logic signed [VtxW-1:0]  vertex_c_x_i,
  input  wire logic signed [VtxW-1:0]  vertex_c_y_i,
  output logic                         valid_o,
  output logic signed [EdgeW-1:0]      left_x_o,
  output logic signed [EdgeW-1:0]      left_slope_o,
  output logic signed [EdgeW-1:0]      right_x_o,
  output logic signed [EdgeW-1:0]      right_slope_o,
  output logic signed [VtxW-1:0]       bottom_y_o,
  output logic signed [VtxW-1:0]       top_y_o,
  output logic                         last_o,
  output logic                         degenerate_o
);

  localparam int NS = DivQW / DivBps;

  logic accept;
  logic busy_q;
  assign accept = start_i && !busy_q;
  assign busy_o = busy_q;

  // stage 1: input capture
  logic                   v1_q;
  logic signed [VtxW-1:0] x1_q [3];
  logic signed [VtxW-1:0] y1_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      v1_q   <= 1'b0;
    end else begin
      busy_q <= accept;
      v1_q   <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x1_q[0] <= vertex_a_x_i;
      y1_q[0] <= vertex_a_y_i;
      x1_q[1] <= vertex_b_x_i;
      y1_q[1] <= vertex_b_y_i;
      x1_q[2] <= vertex_c_x_i;
      y1_q[2] <= vertex_c_y_i;
    end
  end

  // stage 2: sort by y, classify
  logic [1:0]             lo, md, hi;
  logic signed [12:0]     ilo, imd, ihi;
  tri_case_e              kind_d;
  logic                   ll_d;
  logic                   v2_q;
  logic signed [VtxW-1:0] xlo2_q, xmd2_q, xhi2_q, ylo2_q, ymd2_q, yhi2_q;
  tri_case_e              kind2_q;
  logic                   ll2_q;

  always_comb begin
    if (y1_q[0] < y1_q[1]) begin
      if (y1_q[1] < y1_q[2]) begin
        lo = 2'd0; md = 2'd1; hi = 2'd2;
      end else if (y1_q[0] < y1_q[2]) begin
        lo = 2'd0; md = 2'd2; hi = 2'd1;
      end else begin
        lo = 2'd2; md = 2'd0; hi = 2'd1;
      end
    end else begin
      if (y1_q[0] < y1_q[2]) begin
        lo = 2'd1; md = 2'd0; hi = 2'd2;
      end else if (y1_q[1] < y1_q[2]) begin
        lo = 2'd1; md = 2'd2; hi = 2'd0;
      end else begin
        lo = 2'd2; md = 2'd1; hi = 2'd0;
      end
    end
    ilo = int_part(y1_q[lo]);
    imd = int_part(y1_q[md]);
    ihi = int_part(y1_q[hi]);
    priority if (imd == ilo && imd == ihi) begin
      kind_d = CASE_FLAT;
    end else if (imd == ilo) begin
      kind_d = CASE_FBOT;
    end else if (imd == ihi) begin
      kind_d = CASE_FTOP;
    end else begin
      kind_d = CASE_SPLIT;
    end
    // long edge on the left for the one-trapezoid cases
    ll_d = (kind_d == CASE_FBOT) ? (x1_q[lo] < x1_q[md]) : (x1_q[hi] < x1_q[md]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    xlo2_q  <= x1_q[lo];
    xmd2_q  <= x1_q[md];
    xhi2_q  <= x1_q[hi];
    ylo2_q  <= y1_q[lo];
    ymd2_q  <= y1_q[md];
    yhi2_q  <= y1_q[hi];
    kind2_q <= kind_d;
    ll2_q   <= ll_d;
  end

  // stage 3: edge differences
  logic                   v3_q;
  logic signed [VtxW:0]   dxl3_q, dxlow3_q, dxup3_q;
  logic [VtxW-1:0]        dyl3_q, dylow3_q, dyup3_q;
  side_t                  sb3_q;
  side_t                  sb3_d;
  logic signed [VtxW:0]   dyl_w, dylow_w, dyup_w;

  assign dyl_w   = {yhi2_q[VtxW-1], yhi2_q} - {ylo2_q[VtxW-1], ylo2_q};
  assign dylow_w = {ymd2_q[VtxW-1], ymd2_q} - {ylo2_q[VtxW-1], ylo2_q};
  assign dyup_w  = {yhi2_q[VtxW-1], yhi2_q} - {ymd2_q[VtxW-1], ymd2_q};

  always_comb begin
    sb3_d           = '0;
    sb3_d.xlo       = xlo2_q;
    sb3_d.xmd       = xmd2_q;
    sb3_d.ylo       = ylo2_q;
    sb3_d.ymd       = ymd2_q;
    sb3_d.yhi       = yhi2_q;
    sb3_d.kind      = kind2_q;
    sb3_d.long_left = ll2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dxl3_q   <= {xhi2_q[VtxW-1], xhi2_q} - {xlo2_q[VtxW-1], xlo2_q};
    dxlow3_q <= {xmd2_q[VtxW-1], xmd2_q} - {xlo2_q[VtxW-1], xlo2_q};
    dxup3_q  <= {xhi2_q[VtxW-1], xhi2_q} - {xmd2_q[VtxW-1], xmd2_q};
    dyl3_q   <= dyl_w[VtxW-1:0];
    dylow3_q <= dylow_w[VtxW-1:0];
    dyup3_q  <= dyup_w[VtxW-1:0];
    sb3_q    <= sb3_d;
  end

  // stage 4: magnitudes, signs, split-point product
  logic                 v4_q;
  logic [VtxW-1:0]      n0_q, n1_q, n2_q, d0_q, d1_q, d2_q, d3_q;
  logic [2*VtxW-1:0]    prod_q;
  side_t                sb4_q;
  side_t                sb4_d;
  logic [VtxW-1:0]      mdxl;
  logic                 fbot3;

  assign mdxl  = mag17(dxl3_q);
  assign fbot3 = (sb3_q.kind == CASE_FBOT);

  always_comb begin
    sb4_d     = sb3_q;
    sb4_d.sg0 = dxl3_q[VtxW];
    sb4_d.sg1 = fbot3 ? dxup3_q[VtxW] : dxlow3_q[VtxW];
    sb4_d.sg2 = dxup3_q[VtxW];
    sb4_d.sg3 = dxl3_q[VtxW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n0_q   <= mdxl;
    d0_q   <= dyl3_q;
    n1_q   <= fbot3 ? mag17(dxup3_q) : mag17(dxlow3_q);
    d1_q   <= fbot3 ? dyup3_q : dylow3_q;
    n2_q   <= mag17(dxup3_q);
    d2_q   <= dyup3_q;
    d3_q   <= dyl3_q;
    prod_q <= mdxl * dylow3_q;
    sb4_q  <= sb4_d;
  end

  // dividers
  logic              dv0, dv1, dv2, dv3;
  logic [DivQW-1:0]  q0, q1, q2, q3;

  tes_div #(.NW(SlopeNW), .QW(DivQW), .DW(VtxW), .BPS(DivBps)) u_div_long (
    .clk_i, .rst_ni, .valid_i(v4_q), .num_i({n0_q, 16'h0000}), .den_i(d0_q),
    .valid_o(dv0), .quo_o(q0)
  );

  tes_div #(.NW(SlopeNW), .QW(DivQW), .DW(VtxW), .BPS(DivBps)) u_div_mid (
    .clk_i, .rst_ni, .valid_i(v4_q), .num_i({n1_q, 16'h0000}), .den_i(d1_q),
    .valid_o(dv1), .quo_o(q1)
  );

  tes_div #(.NW(SlopeNW), .QW(DivQW), .DW(VtxW), .BPS(DivBps)) u_div_up (
    .clk_i, .rst_ni, .valid_i(v4_q), .num_i({n2_q, 16'h0000}), .den_i(d2_q),
    .valid_o(dv2), .quo_o(q2)
  );

  tes_div #(.NW(OffNW), .QW(DivQW), .DW(VtxW), .BPS(DivBps)) u_div_off (
    .clk_i, .rst_ni, .valid_i(v4_q), .num_i({prod_q, 12'h000}), .den_i(d3_q),
    .valid_o(dv3), .quo_o(q3)
  );

  // sideband delay matched to the divider latency
  side_t sbd_q [NS];

  always_ff @(posedge clk_i) begin
    sbd_q[0] <= sb4_q;
    for (int i = 1; i < NS; i++) begin
      sbd_q[i] <= sbd_q[i-1];
    end
  end

  // stage 5: slope saturation, signed offset
  logic                    v5_q;
  logic signed [EdgeW-1:0] sl0_q, sl1_q, sl2_q, off_q, lx5_q, mx5_q;
  side_t                   sb5_q;
  side_t                   sbo;
  logic                    dvalid;

  assign sbo    = sbd_q[NS-1];
  assign dvalid = dv0 && dv1 && dv2 && dv3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= dvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    sl0_q <= sat_slope(sbo.sg0, q0);
    sl1_q <= sat_slope(sbo.sg1, q1);
    sl2_q <= sat_slope(sbo.sg2, q2);
    off_q <= sbo.sg3 ? -q3 : q3;
    lx5_q <= to_q16(sbo.xlo);
    mx5_q <= to_q16(sbo.xmd);
    sb5_q <= sbo;
  end

  // stage 6: split point, trapezoid assembly, output
  logic signed [EdgeW-1:0] isx;
  logic                    isx_lt;
  res_t                    r0, r1;
  logic                    two;
  res_t                    out_q, hold_q;
  logic                    vout_q, pend_q;

  assign isx    = lx5_q + off_q;
  assign isx_lt = isx < mx5_q;

  always_comb begin
    r0       = '0;
    r1       = '0;
    two      = 1'b0;
    r0.by    = sb5_q.ylo;
    r0.ty    = sb5_q.yhi;
    r0.last  = 1'b1;
    r1.by    = sb5_q.ymd;
    r1.ty    = sb5_q.yhi;
    r1.last  = 1'b1;
    unique case (sb5_q.kind)
      CASE_FLAT: begin
        r0.degen = 1'b1;
      end
      CASE_FBOT: begin
        if (sb5_q.long_left) begin
          r0.lx = lx5_q; r0.ls = sl0_q; r0.rx = mx5_q; r0.rs = sl1_q;
        end else begin
          r0.lx = mx5_q; r0.ls = sl1_q; r0.rx = lx5_q; r0.rs = sl0_q;
        end
      end
      CASE_FTOP: begin
        r0.lx = lx5_q;
        r0.rx = lx5_q;
        if (sb5_q.long_left) begin
          r0.ls = sl0_q; r0.rs = sl1_q;
        end else begin
          r0.ls = sl1_q; r0.rs = sl0_q;
        end
      end
      CASE_SPLIT: begin
        two     = 1'b1;
        r0.ty   = sb5_q.ymd;
        r0.last = 1'b0;
        r0.lx   = lx5_q;
        r0.rx   = lx5_q;
        if (isx_lt) begin
          r0.ls = sl0_q; r0.rs = sl1_q;
          r1.lx = isx;   r1.ls = sl0_q; r1.rx = mx5_q; r1.rs = sl2_q;
        end else begin
          r0.ls = sl1_q; r0.rs = sl0_q;
          r1.lx = mx5_q; r1.ls = sl2_q; r1.rx = isx;   r1.rs = sl0_q;
        end
      end
      default: begin
        r0.degen = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      vout_q <= v5_q || pend_q;
      pend_q <= v5_q && two;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v5_q) begin
      out_q  <= r0;
      hold_q <= r1;
    end else if (pend_q) begin
      out_q  <= hold_q;
    end
  end

  assign valid_o       = vout_q;
  assign left_x_o      = out_q.lx;
  assign left_slope_o  = out_q.ls;
  assign right_x_o     = out_q.rx;
  assign right_slope_o = out_q.rs;
  assign bottom_y_o    = out_q.by;
  assign top_y_o       = out_q.ty;
  assign last_o        = out_q.last;
  assign degenerate_o  = out_q.degen;

endmodule

`default_nettype wire

// ===== rtl/tes_chk.sv =====
// Port-level checker for triangle_edge_setup_core, bound to the top level.
// Depends on tes_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module tes_chk import tes_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   start_i,
  input wire logic                   busy_o,
  input wire logic                   valid_o,
  input wire logic signed [VtxW-1:0] bottom_y_o,
  input wire logic signed [VtxW-1:0] top_y_o,
  input wire logic                   last_o,
  input wire logic                   degenerate_o
);

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy not raised after a request");

  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |=> valid_o && last_o)
    else $error("second trapezoid missing");

  a_split_seam: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |=> bottom_y_o == $past(top_y_o))
    else $error("split trapezoids do not meet");

  a_degen_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && degenerate_o |-> last_o)
    else $error("degenerate result not last");

endmodule

bind triangle_edge_setup_core tes_chk u_tes_chk (
  .clk_i, .rst_ni, .start_i, .busy_o, .valid_o, .bottom_y_o, .top_y_o,
  .last_o, .degenerate_o
);

`default_nettype wire
